// ===== hdl/triangle_point_projection_defines.svh =====
// shared assertion macros
`ifndef TRIANGLE_POINT_PROJECTION_DEFINES_SVH
`define TRIANGLE_POINT_PROJECTION_DEFINES_SVH

// condition that holds on every clock edge out of reset
`define TPP_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication checked on every clock edge out of reset
`define TPP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tpp_pkg.sv =====
package tpp_pkg;

   localparam int COORD_WIDTH      = 24;
   localparam int WEIGHT_FRAC_BITS = 16;

   localparam int DIFF_W   = COORD_WIDTH + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int CROSS_W  = PROD_W + 1;
   localparam int WPROD_W  = 2 * CROSS_W;
   localparam int DOT_W    = WPROD_W + 2;
   localparam int NUM_W    = DOT_W + 3;
   localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;

   localparam int FRONT_LAT = 3;
   localparam int MUL_LAT   = 3;
   localparam int DOT_LAT   = MUL_LAT + 1;
   localparam int SEL_LAT   = 2;
   localparam int LATENCY   = FRONT_LAT + DOT_LAT + SEL_LAT + WEIGHT_W;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [CROSS_W-1:0]     cross_type;
   typedef logic signed [WPROD_W-1:0]     wprod_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic signed [NUM_W-1:0]       num_type;

   typedef struct packed {
      coord_type v0_x;
      coord_type v0_y;
      coord_type v0_z;
      coord_type v1_x;
      coord_type v1_y;
      coord_type v1_z;
      coord_type v2_x;
      coord_type v2_y;
      coord_type v2_z;
      coord_type p_x;
      coord_type p_y;
      coord_type p_z;
   } req_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight_vertex0;
      logic [WEIGHT_W-1:0] weight_vertex1;
      logic                inside_res;
      logic                degenerate;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0]    den;
      logic [NUM_W-1:0]    rem0;
      logic [NUM_W-1:0]    rem1;
      logic [WEIGHT_W-1:0] quo0;
      logic [WEIGHT_W-1:0] quo1;
      logic                inside_res;
      logic                degenerate;
   } div_stage_type;

endpackage

// ===== hdl/triangle_point_projection.sv =====
// Projects a point onto a triangle and returns clamped barycentric weights of
// vertex 0 and vertex 1 (unsigned Q1.16, truncated) with inside and degenerate
// flags. The pipeline takes one request every clock cycle and busy is always
// low. Each result appears on rsp_data for a single cycle with rsp_valid,
// once its request has gone through the stages for edges and cross
// products, the split wide multipliers and dot sums, the weight numerators
// and case selection, and the restoring divider that yields one quotient
// bit per stage. Results cannot be held off, so the receiver must take
// every result in the cycle it is shown.
module triangle_point_projection (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tpp_pkg::req_type  req_data,
   output logic              rsp_valid,
   output tpp_pkg::rsp_type  rsp_data
);
   import tpp_pkg::*;

   logic          fr_valid;
   cross_type     nrm [3];
   cross_type     txe [3];
   cross_type     ext [3];
   logic          dot_valid;
   dot_type       dd, da, db;
   num_type       d_ff, a_ff, b_ff, c_ff;
   logic [1:0]    vld_ff;
   div_stage_type sel_in;
   div_stage_type sel_ff;
   logic          pa, pb, pc, degen;
   num_type       one_w;

   assign busy = 1'b0;

   tpp_front u_front (
      .clock(clock), .reset(reset), .in_valid(start & ~busy), .in_data(req_data),
      .out_valid(fr_valid), .nrm(nrm), .txe(txe), .ext(ext)
   );

   tpp_dot u_dot (
      .clock(clock), .reset(reset), .in_valid(fr_valid), .nrm(nrm), .txe(txe),
      .ext(ext), .out_valid(dot_valid), .dd(dd), .da(da), .db(db)
   );

   always_ff @(posedge clock) begin
      d_ff <= NUM_W'(dd);
      a_ff <= NUM_W'(da);
      b_ff <= NUM_W'(db);
      c_ff <= NUM_W'(dd) - NUM_W'(da) - NUM_W'(db);
   end

   assign one_w = NUM_W'(1);
   assign pa    = ~a_ff[NUM_W-1];
   assign pb    = ~b_ff[NUM_W-1];
   assign pc    = ~c_ff[NUM_W-1];
   assign degen = (d_ff == '0);

   always_comb begin
      num_type n0, n1, dn;
      n0 = '0;
      n1 = '0;
      dn = one_w;
      sel_in.inside_res = 1'b0;
      sel_in.degenerate = degen;
      if (degen) begin
         dn = one_w;
      end else if (pa && pb && pc) begin
         n0 = c_ff;
         n1 = a_ff;
         dn = d_ff;
         sel_in.inside_res = 1'b1;
      end else if (pa && pb) begin
         n1 = a_ff;
         dn = a_ff + b_ff;
      end else if (pa && pc) begin
         n0 = c_ff;
         n1 = a_ff;
         dn = a_ff + c_ff;
      end else if (pa) begin
         n1 = one_w;
      end else if (pb && pc) begin
         n0 = c_ff;
         dn = b_ff + c_ff;
      end else if (!pb) begin
         n0 = one_w;
      end
      sel_in.den  = unsigned'(dn);
      sel_in.rem0 = unsigned'(n0);
      sel_in.rem1 = unsigned'(n1);
      sel_in.quo0 = '0;
      sel_in.quo1 = '0;
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], dot_valid};
      end
   end

   tpp_div u_div (
      .clock(clock), .reset(reset), .in_valid(vld_ff[1]), .in_data(sel_ff),
      .out_valid(rsp_valid), .out_data(rsp_data)
   );

endmodule

// ===== hdl/tpp_wmul.sv =====
module tpp_wmul #(
   parameter int A_W = 51
) (
   input  logic                      clock,
   input  logic signed [A_W-1:0]     a,
   input  logic signed [A_W-1:0]     b,
   output logic signed [2*A_W-1:0]   p
);
   localparam int HALF = (A_W + 1) / 2;
   localparam int HI_W = A_W - HALF;
   localparam int P_W  = 2 * A_W;

   logic [A_W-1:0]          a_mag;
   logic [A_W-1:0]          b_mag;
   logic [2*HALF-1:0]       ll_ff;
   logic [HALF+HI_W-1:0]    lh_ff;
   logic [HALF+HI_W-1:0]    hl_ff;
   logic [2*HI_W-1:0]       hh_ff;
   logic                    neg1_ff;
   logic [P_W-1:0]          sum_in;
   logic [P_W-1:0]          sum_ff;
   logic                    neg2_ff;
   logic [P_W-1:0]          p_in;
   logic [P_W-1:0]          p_ff;

   assign a_mag = a[A_W-1] ? A_W'(-a) : A_W'(a);
   assign b_mag = b[A_W-1] ? A_W'(-b) : A_W'(b);

   always_ff @(posedge clock) begin
      ll_ff   <= a_mag[HALF-1:0] * b_mag[HALF-1:0];
      lh_ff   <= a_mag[HALF-1:0] * b_mag[A_W-1:HALF];
      hl_ff   <= a_mag[A_W-1:HALF] * b_mag[HALF-1:0];
      hh_ff   <= a_mag[A_W-1:HALF] * b_mag[A_W-1:HALF];
      neg1_ff <= a[A_W-1] ^ b[A_W-1];
   end

   assign sum_in = P_W'(ll_ff) + (P_W'(lh_ff) << HALF) + (P_W'(hl_ff) << HALF)
                 + (P_W'(hh_ff) << (2 * HALF));

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      neg2_ff <= neg1_ff;
   end

   assign p_in = neg2_ff ? P_W'(-sum_ff) : sum_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = signed'(p_ff);

endmodule

// ===== hdl/tpp_front.sv =====
module tpp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  tpp_pkg::req_type     in_data,
   output logic                 out_valid,
   output tpp_pkg::cross_type   nrm [3],
   output tpp_pkg::cross_type   txe [3],
   output tpp_pkg::cross_type   ext [3]
);
   import tpp_pkg::*;

   coord_type v0 [3];
   coord_type v1 [3];
   coord_type v2 [3];
   coord_type pt [3];
   diff_type  e0_ff [3];
   diff_type  e1_ff [3];
   diff_type  t_ff  [3];
   prod_type  pa_ff [3][3];
   prod_type  pb_ff [3][3];
   cross_type cr_ff [3][3];
   logic [FRONT_LAT-1:0] vld_ff;

   assign v0 = '{in_data.v0_x, in_data.v0_y, in_data.v0_z};
   assign v1 = '{in_data.v1_x, in_data.v1_y, in_data.v1_z};
   assign v2 = '{in_data.v2_x, in_data.v2_y, in_data.v2_z};
   assign pt = '{in_data.p_x, in_data.p_y, in_data.p_z};

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e0_ff[i] <= DIFF_W'(v1[i]) - DIFF_W'(v0[i]);
         e1_ff[i] <= DIFF_W'(v2[i]) - DIFF_W'(v0[i]);
         t_ff[i]  <= DIFF_W'(pt[i]) - DIFF_W'(v0[i]);
      end
   end

   // normal, t x e1, e0 x t
   for (genvar g = 0; g < 3; g++) begin : g_grp
      for (genvar i = 0; i < 3; i++) begin : g_cmp
         localparam int J = (i + 1) % 3;
         localparam int K = (i + 2) % 3;
         diff_type lj, lk, rj, rk;
         assign lj = (g == 1) ? t_ff[J] : e0_ff[J];
         assign lk = (g == 1) ? t_ff[K] : e0_ff[K];
         assign rj = (g == 2) ? t_ff[J] : e1_ff[J];
         assign rk = (g == 2) ? t_ff[K] : e1_ff[K];
         always_ff @(posedge clock) begin
            pa_ff[g][i] <= lj * rk;
            pb_ff[g][i] <= lk * rj;
            cr_ff[g][i] <= CROSS_W'(pa_ff[g][i]) - CROSS_W'(pb_ff[g][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FRONT_LAT-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[FRONT_LAT-1];
   assign nrm = cr_ff[0];
   assign txe = cr_ff[1];
   assign ext = cr_ff[2];

endmodule

// ===== hdl/tpp_dot.sv =====
module tpp_dot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  tpp_pkg::cross_type   nrm [3],
   input  tpp_pkg::cross_type   txe [3],
   input  tpp_pkg::cross_type   ext [3],
   output logic                 out_valid,
   output tpp_pkg::dot_type     dd,
   output tpp_pkg::dot_type     da,
   output tpp_pkg::dot_type     db
);
   import tpp_pkg::*;

   wprod_type pn [3];
   wprod_type pa [3];
   wprod_type pb [3];
   dot_type   dd_ff;
   dot_type   da_ff;
   dot_type   db_ff;
   logic [DOT_LAT-1:0] vld_ff;

   for (genvar i = 0; i < 3; i++) begin : g_mul
      tpp_wmul #(.A_W(CROSS_W)) u_mn (.clock(clock), .a(nrm[i]), .b(nrm[i]), .p(pn[i]));
      tpp_wmul #(.A_W(CROSS_W)) u_ma (.clock(clock), .a(nrm[i]), .b(txe[i]), .p(pa[i]));
      tpp_wmul #(.A_W(CROSS_W)) u_mb (.clock(clock), .a(nrm[i]), .b(ext[i]), .p(pb[i]));
   end

   always_ff @(posedge clock) begin
      dd_ff <= DOT_W'(pn[0]) + DOT_W'(pn[1]) + DOT_W'(pn[2]);
      da_ff <= DOT_W'(pa[0]) + DOT_W'(pa[1]) + DOT_W'(pa[2]);
      db_ff <= DOT_W'(pb[0]) + DOT_W'(pb[1]) + DOT_W'(pb[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DOT_LAT-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[DOT_LAT-1];
   assign dd = dd_ff;
   assign da = da_ff;
   assign db = db_ff;

endmodule

// ===== hdl/tpp_div.sv =====
module tpp_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  tpp_pkg::div_stage_type  in_data,
   output logic                    out_valid,
   output tpp_pkg::rsp_type        out_data
);
   import tpp_pkg::*;

   div_stage_type stg_ff [WEIGHT_W];
   logic [WEIGHT_W-1:0] vld_ff;

   // one quotient bit per stage, both weights share the divisor
   for (genvar s = 0; s < WEIGHT_W; s++) begin : g_step
      div_stage_type src;
      logic [NUM_W-1:0] try0, try1;
      logic ge0, ge1;
      if (s == 0) begin : g_first
         assign src = in_data;
      end else begin : g_next
         assign src = stg_ff[s-1];
      end
      assign try0 = (s == 0) ? src.rem0 : {src.rem0[NUM_W-2:0], 1'b0};
      assign try1 = (s == 0) ? src.rem1 : {src.rem1[NUM_W-2:0], 1'b0};
      assign ge0  = try0 >= src.den;
      assign ge1  = try1 >= src.den;
      always_ff @(posedge clock) begin
         stg_ff[s].den        <= src.den;
         stg_ff[s].rem0       <= ge0 ? try0 - src.den : try0;
         stg_ff[s].rem1       <= ge1 ? try1 - src.den : try1;
         stg_ff[s].quo0       <= {src.quo0[WEIGHT_W-2:0], ge0};
         stg_ff[s].quo1       <= {src.quo1[WEIGHT_W-2:0], ge1};
         stg_ff[s].inside_res <= src.inside_res;
         stg_ff[s].degenerate <= src.degenerate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[WEIGHT_W-2:0], in_valid};
      end
   end

   assign out_valid               = vld_ff[WEIGHT_W-1];
   assign out_data.weight_vertex0 = stg_ff[WEIGHT_W-1].quo0;
   assign out_data.weight_vertex1 = stg_ff[WEIGHT_W-1].quo1;
   assign out_data.inside_res     = stg_ff[WEIGHT_W-1].inside_res;
   assign out_data.degenerate     = stg_ff[WEIGHT_W-1].degenerate;

endmodule

// ===== hdl/tpp_checker.sv =====
`include "triangle_point_projection_defines.svh"

module tpp_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input tpp_pkg::rsp_type  rsp_data
);
   import tpp_pkg::*;

   logic [WEIGHT_W:0] wsum;

   assign wsum = {1'b0, rsp_data.weight_vertex0} + {1'b0, rsp_data.weight_vertex1};

   `TPP_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy, "busy raised")
   `TPP_ASSERT_IMPLY(a_rsp_from_req, clock, reset, rsp_valid,
      $past(start && !busy, LATENCY), "result without request")
   `TPP_ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate,
      rsp_data.weight_vertex0 == '0 && rsp_data.weight_vertex1 == '0
      && !rsp_data.inside_res, "degenerate result not cleared")
   `TPP_ASSERT_IMPLY(a_weight_sum, clock, reset, rsp_valid,
      wsum <= ((WEIGHT_W+1)'(1) << WEIGHT_FRAC_BITS), "weights exceed one")

endmodule

bind triangle_point_projection tpp_checker u_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
   import tpp_pkg::*;

   typedef logic signed [159:0] wide_t;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } row_t;

   localparam int LIMIT_CYCLES = 400000;
   localparam int ONE_W        = 1 << WEIGHT_FRAC_BITS;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic    typed_flag;
   rsp_type typed_want;

   rsp_type weights_due[$];
   int      failures;
   int      cycles;
   bit      quiet;

   triangle_point_projection u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic wide_t dot3(input wide_t a[3], input wide_t b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   function automatic logic [WEIGHT_W-1:0] ratio(input wide_t num, input wide_t den);
      wide_t q;
      q = (num <<< WEIGHT_FRAC_BITS) / den;
      return q[WEIGHT_W-1:0];
   endfunction

   function automatic rsp_type project_point(input req_type r);
      wide_t   e0[3], e1[3], t[3], nrm[3], tmp[3];
      wide_t   den, na, nb, nc;
      bit      pa, pb, pc;
      rsp_type o;
      e0[0] = wide_t'(r.v1_x) - wide_t'(r.v0_x);
      e0[1] = wide_t'(r.v1_y) - wide_t'(r.v0_y);
      e0[2] = wide_t'(r.v1_z) - wide_t'(r.v0_z);
      e1[0] = wide_t'(r.v2_x) - wide_t'(r.v0_x);
      e1[1] = wide_t'(r.v2_y) - wide_t'(r.v0_y);
      e1[2] = wide_t'(r.v2_z) - wide_t'(r.v0_z);
      t[0]  = wide_t'(r.p_x) - wide_t'(r.v0_x);
      t[1]  = wide_t'(r.p_y) - wide_t'(r.v0_y);
      t[2]  = wide_t'(r.p_z) - wide_t'(r.v0_z);
      o = '0;
      cross3(e0, e1, nrm);
      den = dot3(nrm, nrm);
      if (den == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      cross3(t, e1, tmp);
      na = dot3(nrm, tmp);
      cross3(e0, t, tmp);
      nb = dot3(nrm, tmp);
      nc = den - na - nb;
      pa = na >= 0;
      pb = nb >= 0;
      pc = nc >= 0;
      if (pa && pb && pc) begin
         o.inside_res     = 1'b1;
         o.weight_vertex0 = ratio(nc, den);
         o.weight_vertex1 = ratio(na, den);
      end else if (pa && pb) begin
         o.weight_vertex1 = ratio(na, na + nb);
      end else if (pa && pc) begin
         o.weight_vertex0 = ratio(nc, na + nc);
         o.weight_vertex1 = ratio(na, na + nc);
      end else if (pa) begin
         o.weight_vertex1 = WEIGHT_W'(ONE_W);
      end else if (pb && pc) begin
         o.weight_vertex0 = ratio(nc, nb + nc);
      end else if (!pb) begin
         o.weight_vertex0 = WEIGHT_W'(ONE_W);
      end
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("[triangle_point_projection] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy)
            weights_due.push_back(typed_flag ? typed_want : project_point(req_data));
         if (rsp_valid) begin
            if (weights_due.size() == 0) begin
               $error("result with no request outstanding");
               failures++;
            end else begin
               want = weights_due.pop_front();
               if (rsp_data.weight_vertex0 !== want.weight_vertex0) begin
                  $error("weight_vertex0 expected %0d got %0d",
                         want.weight_vertex0, rsp_data.weight_vertex0);
                  failures++;
               end
               if (rsp_data.weight_vertex1 !== want.weight_vertex1) begin
                  $error("weight_vertex1 expected %0d got %0d",
                         want.weight_vertex1, rsp_data.weight_vertex1);
                  failures++;
               end
               if (rsp_data.inside_res !== want.inside_res) begin
                  $error("inside_res expected %0d got %0d",
                         want.inside_res, rsp_data.inside_res);
                  failures++;
               end
               if (rsp_data.degenerate !== want.degenerate) begin
                  $error("degenerate expected %0d got %0d",
                         want.degenerate, rsp_data.degenerate);
                  failures++;
               end
            end
         end
      end
   end

   function automatic coord_type rnd_coord(input int span);
      if (span == 0)
         return coord_type'($urandom);
      return coord_type'($urandom_range(2 * span) - span);
   endfunction

   function automatic req_type rnd_request();
      req_type r;
      int      span;
      int      pick;
      pick = $urandom_range(9);
      span = (pick < 3) ? 0 : (pick < 6) ? 8192 : (pick < 8) ? 300000 : 64;
      r = {rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span),
           rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span),
           rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span)};
      case ($urandom_range(15))
         0: begin
            r.v2_x = r.v0_x;
            r.v2_y = r.v0_y;
            r.v2_z = r.v0_z;
         end
         1: begin
            r.v2_x = r.v1_x + r.v1_x - r.v0_x;
            r.v2_y = r.v1_y + r.v1_y - r.v0_y;
            r.v2_z = r.v1_z + r.v1_z - r.v0_z;
         end
         2: begin
            r.p_x = r.v1_x;
            r.p_y = r.v1_y;
            r.p_z = r.v1_z;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send(input req_type r, input bit typed, input rsp_type want);
      start      <= 1'b1;
      req_data   <= r;
      typed_flag <= typed;
      typed_want <= want;
      do @(posedge clock); while (busy);
      if (!quiet && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (weights_due.size() != 0) @(posedge clock);
   endtask

   localparam coord_type CMAX = coord_type'(24'h7FFFFF);
   localparam coord_type CMIN = coord_type'(24'h800000);
   localparam coord_type U    = coord_type'(4096);

   row_t    rows[$];
   row_t    rw;
   rsp_type none;

   initial begin
      failures   = 0;
      cycles     = 0;
      quiet      = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      typed_flag = 1'b0;
      typed_want = '0;
      none       = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // degenerate: all zero, collinear
      rw = '{'0, 1, '{0, 0, 0, 1}};
      rows.push_back(rw);
      rw = '{'{U, 0, 0, 2 * U, 0, 0, 3 * U, 0, 0, U, U, U}, 1, '{0, 0, 0, 1}};
      rows.push_back(rw);
      // point on vertex 0 and vertex 1
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, 0, 0, U}, 1, '{ONE_W, 0, 1, 0}};
      rows.push_back(rw);
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, U, 0, -U}, 1, '{0, ONE_W, 1, 0}};
      rows.push_back(rw);
      // snap to vertex 0, vertex 1, vertex 2
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, -U, -U, 0}, 1, '{ONE_W, 0, 0, 0}};
      rows.push_back(rw);
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, 3 * U, -U, 0}, 0, none};
      rows.push_back(rw);
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, -U, 3 * U, 0}, 1, '{0, 0, 0, 0}};
      rows.push_back(rw);
      // clamp to each edge
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, U / 2, -U, 0}, 0, none};
      rows.push_back(rw);
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, U, U, 0}, 0, none};
      rows.push_back(rw);
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, -U, U / 3, 0}, 0, none};
      rows.push_back(rw);
      // inside, zero weight on edges
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, U / 4, U / 3, 7}, 0, none};
      rows.push_back(rw);
      rw = '{'{0, 0, 0, U, 0, 0, 0, U, 0, U / 2, U / 2, 0}, 0, none};
      rows.push_back(rw);
      // coordinate extremes
      rw = '{'{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN,
               CMAX, CMAX, CMAX}, 0, none};
      rows.push_back(rw);
      rw = '{'{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX,
               CMIN, CMIN, CMIN}, 0, none};
      rows.push_back(rw);
      rw = '{'{CMIN, 0, CMAX, CMAX, CMIN, 0, 0, CMAX, CMIN, 0, 0, 0}, 0, none};
      rows.push_back(rw);
      rw = '{'{-1, -1, -1, 1, -1, -1, -1, 1, -1, 0, 0, 0}, 0, none};
      rows.push_back(rw);

      foreach (rows[i])
         send(rows[i].req, rows[i].typed, rows[i].want);

      for (int n = 0; n < 1300; n++) begin
         if (n == 400 || n == 800)
            drain();
         if (n == 1150)
            quiet = 1;
         send(rnd_request(), 1'b0, none);
      end
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (failures == 0)
         $display("[triangle_point_projection] OK");
      else
         $display("[triangle_point_projection] ERROR");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/tpp_pkg.sv
hdl/tpp_wmul.sv
hdl/tpp_front.sv
hdl/tpp_dot.sv
hdl/tpp_div.sv
hdl/triangle_point_projection.sv
hdl/tpp_checker.sv
test/tb_top.sv
